// ===== design/afm_pkg.sv =====
// shared types and constants of the appliance fault monitor
`default_nettype none

package afm_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HAVE_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAP_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PUMP_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK_DELAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REMINDER   = 3'd5;

    // configuration reset values
    localparam logic [31:0] LOST_DELAY_RST = 32'd20000;
    localparam logic [31:0] HAVE_DELAY_RST = 32'd10000;
    localparam logic [7:0]  FLAP_LIMIT_RST = 8'd10;
    localparam logic [31:0] PUMP_LIMIT_RST = 32'd18000000;
    localparam logic [31:0] LEAK_DELAY_RST = 32'd10000;
    localparam logic [31:0] REMINDER_RST   = 32'd3600000;

    // stream widths
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [31:0] lost_delay_ms;
        logic [31:0] have_delay_ms;
        logic [7:0]  flap_limit;
        logic [31:0] pump_limit_ms;
        logic [31:0] leak_delay_ms;
        logic [31:0] reminder_ms;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        pressure_ok;
        logic [3:0]  filter_time_zero;
        logic [3:0]  filter_expire_zero;
        logic [31:0] pump_run_ms;
        logic        leak_detected;
        logic [2:0]  shown_error;
    } t_tick;

    typedef struct packed {
        logic [7:0] error_flags;
        logic [7:0] new_errors;
        logic [2:0] recent_error;
        logic       pump_off;
        logic       cancel_display;
        logic       all_cleared;
        logic       any_error;
        logic [2:0] next_error;
        logic       next_found;
    } t_result;

endpackage

`default_nettype wire

// ===== design/afm_engine.sv =====
// fault check engine: sticky error state and the per-tick checks
`default_nettype none

module afm_engine #(
    parameter int FILTERS     = 4,
    parameter int ERROR_CODES = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_step,
    input  afm_pkg::t_tick   i_tick,
    input  afm_pkg::t_cfg    i_cfg,
    output afm_pkg::t_result o_result
);

    localparam int FW = (FILTERS + 4 > ERROR_CODES) ? FILTERS + 4 : ERROR_CODES;
    localparam int CW = $clog2(FW);
    localparam int CODE_LOST     = FILTERS;
    localparam int CODE_UNSTABLE = FILTERS + 1;
    localparam int CODE_PUMP     = FILTERS + 2;
    localparam int CODE_LEAK     = FILTERS + 3;

    typedef enum logic [1:0] {
        WS_NORMAL   = 2'd0,
        WS_LOST     = 2'd1,
        WS_UNSTABLE = 2'd2
    } t_water;

    logic [FW-1:0] r_flags, n_flags;
    logic          r_prev_press, n_prev_press;
    t_water        r_water, n_water;
    logic [31:0]   r_water_since, n_water_since;
    logic [31:0]   r_dry_since, n_dry_since;
    logic [7:0]    r_flap, n_flap;
    logic [31:0]   r_last_rem, n_last_rem;
    logic          r_leak_pend, n_leak_pend;
    logic [31:0]   r_leak_since, n_leak_since;
    logic          r_prev_any, n_prev_any;
    logic [CW-1:0] r_latest, n_latest;

    logic [FW-1:0] new_flags;
    logic          pump_off;
    logic          cancel;
    logic          cleared;
    logic          any_err;
    logic [CW-1:0] next_code;
    logic          found;
    logic [7:0]    spent;

    assign spent = {4'b0000, i_tick.filter_time_zero | i_tick.filter_expire_zero};

    // one tick of checks, in the order the sticky state demands
    always_comb begin
        logic [31:0] now;
        now           = i_tick.now_ms;
        n_flags       = r_flags;
        n_prev_press  = r_prev_press;
        n_water       = r_water;
        n_water_since = r_water_since;
        n_dry_since   = r_dry_since;
        n_flap        = r_flap;
        n_last_rem    = r_last_rem;
        n_leak_pend   = r_leak_pend;
        n_leak_since  = r_leak_since;
        n_latest      = r_latest;
        new_flags     = '0;
        pump_off      = 1'b0;
        cancel        = 1'b0;

        // filter expiry
        for (int i = 0; i < FILTERS; i++) begin
            if (spent[i]) begin
                if (!n_flags[i]) begin
                    n_flags[i]   = 1'b1;
                    new_flags[i] = 1'b1;
                    n_latest     = CW'(i);
                end
            end else begin
                n_flags[i] = 1'b0;
            end
        end

        // inlet water supply
        if (i_tick.pressure_ok) begin
            if (!n_prev_press) begin
                n_prev_press  = 1'b1;
                n_water_since = now;
            end else if ((now - n_water_since) > i_cfg.have_delay_ms) begin
                n_flap = 8'd0;
                if (n_water != WS_NORMAL) begin
                    n_water                = WS_NORMAL;
                    n_flags[CODE_LOST]     = 1'b0;
                    n_flags[CODE_UNSTABLE] = 1'b0;
                end
            end
            if (n_water == WS_LOST) begin
                n_water            = WS_NORMAL;
                n_flags[CODE_LOST] = 1'b0;
                if (n_latest == CW'(CODE_LOST)) begin
                    cancel = 1'b1;
                end
            end
        end else if (n_prev_press) begin
            n_prev_press = 1'b0;
            n_dry_since  = now;
            if ((now - n_water_since) < i_cfg.have_delay_ms) begin
                n_flap = n_flap + 8'd1;
                if (n_flap >= i_cfg.flap_limit && n_water != WS_UNSTABLE) begin
                    n_water                  = WS_UNSTABLE;
                    n_flags[CODE_LOST]       = 1'b0;
                    n_flags[CODE_UNSTABLE]   = 1'b1;
                    new_flags[CODE_UNSTABLE] = 1'b1;
                    n_latest                 = CW'(CODE_UNSTABLE);
                    n_flap                   = 8'd0;
                end
            end
        end
        if (!i_tick.pressure_ok && !n_prev_press &&
            (now - n_dry_since) > i_cfg.lost_delay_ms && n_water != WS_LOST) begin
            n_water                = WS_LOST;
            n_flags[CODE_UNSTABLE] = 1'b0;
            n_flags[CODE_LOST]     = 1'b1;
            new_flags[CODE_LOST]   = 1'b1;
            n_latest               = CW'(CODE_LOST);
            n_last_rem             = now;
        end

        // pump overtime
        if (i_tick.pump_run_ms > i_cfg.pump_limit_ms && !n_flags[CODE_PUMP]) begin
            pump_off             = 1'b1;
            n_flags[CODE_PUMP]   = 1'b1;
            new_flags[CODE_PUMP] = 1'b1;
            n_latest             = CW'(CODE_PUMP);
        end

        // held leak
        if (i_tick.leak_detected && !n_flags[CODE_LEAK]) begin
            if (!n_leak_pend) begin
                n_leak_pend  = 1'b1;
                n_leak_since = now;
            end
            if ((now - n_leak_since) >= i_cfg.leak_delay_ms) begin
                pump_off             = 1'b1;
                n_flags[CODE_LEAK]   = 1'b1;
                new_flags[CODE_LEAK] = 1'b1;
                n_latest             = CW'(CODE_LEAK);
            end
        end

        // all-cleared edge is taken before the reminder
        n_prev_any = (n_flags != '0);
        cleared    = r_prev_any && !n_prev_any;

        // periodic re-raise while water stays lost
        if (n_flags[CODE_LOST] && (now - n_last_rem) > i_cfg.reminder_ms) begin
            new_flags[CODE_LOST] = 1'b1;
            n_latest             = CW'(CODE_LOST);
            n_last_rem           = now;
        end

        any_err = (n_flags != '0);
    end

    // next set code after the shown one, shown code last
    always_comb begin
        int            first;
        int            cand;
        logic [CW-1:0] idx;
        first     = (int'(i_tick.shown_error) + 1 >= ERROR_CODES) ? 0
                    : int'(i_tick.shown_error) + 1;
        found     = 1'b0;
        next_code = '0;
        for (int k = 0; k < ERROR_CODES; k++) begin
            cand = first + k;
            if (cand >= ERROR_CODES) begin
                cand = cand - ERROR_CODES;
            end
            idx = CW'(cand);
            if (!found && n_flags[idx]) begin
                found     = 1'b1;
                next_code = idx;
            end
        end
    end

    // result fields, flags shown in the low eight bits
    always_comb begin
        logic [FW+7:0] flags_x;
        logic [FW+7:0] new_x;
        flags_x                 = {8'b0, n_flags};
        new_x                   = {8'b0, new_flags};
        o_result.error_flags    = flags_x[7:0];
        o_result.new_errors     = new_x[7:0];
        o_result.recent_error   = n_latest[2:0];
        o_result.pump_off       = pump_off;
        o_result.cancel_display = cancel;
        o_result.all_cleared    = cleared;
        o_result.any_error      = any_err;
        o_result.next_error     = next_code[2:0];
        o_result.next_found     = found;
    end

    // state update on each tick taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags       <= '0;
            r_prev_press  <= 1'b1;
            r_water       <= WS_NORMAL;
            r_water_since <= '0;
            r_dry_since   <= '0;
            r_flap        <= '0;
            r_last_rem    <= '0;
            r_leak_pend   <= 1'b0;
            r_leak_since  <= '0;
            r_prev_any    <= 1'b0;
            r_latest      <= '0;
        end else if (i_step) begin
            r_flags       <= n_flags;
            r_prev_press  <= n_prev_press;
            r_water       <= n_water;
            r_water_since <= n_water_since;
            r_dry_since   <= n_dry_since;
            r_flap        <= n_flap;
            r_last_rem    <= n_last_rem;
            r_leak_pend   <= n_leak_pend;
            r_leak_since  <= n_leak_since;
            r_prev_any    <= n_prev_any;
            r_latest      <= n_latest;
        end
    end

endmodule

`default_nettype wire

// ===== design/appliance_fault_monitor_core.sv =====
// top level of the appliance fault monitor: stream ports, config registers, pipeline
// A transferred tick lands in an input register, the check engine evaluates it in
// one pass of compare logic and the result lands in an output register. A new tick
// can enter an empty input register while a finished result waits, but a full input
// register only takes a new tick when its own tick steps into a free result slot;
// the sustained rate is one tick per cycle as long as results are taken.
// The user must write configuration through the plain write port only while no tick
// is in flight; the block itself does not enforce it. There is no clearing pass after reset.
`default_nettype none

module appliance_fault_monitor_core #(
    parameter int FILTERS     = 4,
    parameter int ERROR_CODES = 8
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // now_ms, pressure_ok, filter_time_zero, filter_expire_zero, pump_run_ms,
    // leak_detected, shown_error, zero fill
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [afm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // error_flags, new_errors, recent_error, pump_off, cancel_display,
    // all_cleared, any_error, next_error, next_found, zero fill
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [afm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire                                  i_cfg_we,
    input  wire  [afm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [31:0]                          i_cfg_wdata
);

    afm_pkg::t_cfg    r_cfg;
    afm_pkg::t_tick   r_in;
    logic             r_in_valid;
    afm_pkg::t_result r_out;
    logic             r_out_valid;
    afm_pkg::t_result step_result;
    logic             out_free;
    logic             step;

    // handshake: the engine steps when a tick waits and the result slot is free
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lost_delay_ms <= afm_pkg::LOST_DELAY_RST;
            r_cfg.have_delay_ms <= afm_pkg::HAVE_DELAY_RST;
            r_cfg.flap_limit    <= afm_pkg::FLAP_LIMIT_RST;
            r_cfg.pump_limit_ms <= afm_pkg::PUMP_LIMIT_RST;
            r_cfg.leak_delay_ms <= afm_pkg::LEAK_DELAY_RST;
            r_cfg.reminder_ms   <= afm_pkg::REMINDER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                afm_pkg::CFG_LOST_DELAY: r_cfg.lost_delay_ms <= i_cfg_wdata;
                afm_pkg::CFG_HAVE_DELAY: r_cfg.have_delay_ms <= i_cfg_wdata;
                afm_pkg::CFG_FLAP_LIMIT: r_cfg.flap_limit    <= i_cfg_wdata[7:0];
                afm_pkg::CFG_PUMP_LIMIT: r_cfg.pump_limit_ms <= i_cfg_wdata;
                afm_pkg::CFG_LEAK_DELAY: r_cfg.leak_delay_ms <= i_cfg_wdata;
                afm_pkg::CFG_REMINDER:   r_cfg.reminder_ms   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.now_ms             <= s_axis_tdata[31:0];
            r_in.pressure_ok        <= s_axis_tdata[32];
            r_in.filter_time_zero   <= s_axis_tdata[36:33];
            r_in.filter_expire_zero <= s_axis_tdata[40:37];
            r_in.pump_run_ms        <= s_axis_tdata[72:41];
            r_in.leak_detected      <= s_axis_tdata[73];
            r_in.shown_error        <= s_axis_tdata[76:74];
        end
    end

    afm_engine #(
        .FILTERS     (FILTERS),
        .ERROR_CODES (ERROR_CODES)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_tick   (r_in),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
        if (step) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0,
                            r_out.next_found,
                            r_out.next_error,
                            r_out.any_error,
                            r_out.all_cleared,
                            r_out.cancel_display,
                            r_out.pump_off,
                            r_out.recent_error,
                            r_out.new_errors,
                            r_out.error_flags};

`ifndef SYNTH
    // a stepped tick always shows up as a pending result
    a_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("stepped tick did not reach the result register");

    // a taken result without a new step leaves the slot empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !step) |=> !m_axis_tvalid)
        else $error("result repeated after transfer");

    // no flag set means the search reports nothing
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.any_error) |-> (!r_out.next_found && r_out.next_error == 3'd0))
        else $error("next error reported with no flag set");

    // the all-cleared pulse only comes with no flags left
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.all_cleared) |-> !r_out.any_error)
        else $error("all cleared with errors still active");
`endif

endmodule

`default_nettype wire
